>>> hw/rtl/dcs_pkg.sv
// Shared types and constants for the distributed clock phase tracker.
package dcs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRAP,
        ST_MULP,
        ST_MULI,
        ST_FIN
    } dcs_state_t;

    typedef logic [0:0] cfg_index_t;

    localparam cfg_index_t CFG_CYCLE_TIME    = 1'b0;
    localparam cfg_index_t CFG_MASTER_OFFSET = 1'b1;

    localparam int unsigned NS_PER_US = 1000;

    localparam logic [30:0] CYCLE_NS_RESET = 31'd1000000;

    localparam logic signed [30:0] INTEG_LIMIT = 31'sd1000000000;

    // Reciprocals for exact truncating division by 100 and by 20.
    localparam logic [31:0] RECIP_PROP  = 32'd2748779070;
    localparam int unsigned SHIFT_PROP  = 38;
    localparam logic [31:0] RECIP_INTEG = 32'd1717986919;
    localparam int unsigned SHIFT_INTEG = 35;

endpackage

>>> hw/rtl/dc_clock_sync_pi_top.sv
// Distributed clock phase tracker with a saturating integral and PI compensation.
//
// Each item carries a distributed clock time in nanoseconds. The block takes
// the remainder of (time - offset) by the cycle time with a bit-serial restoring
// remainder unit that handles one dividend bit per cycle. Each item passes through
// an idle state, 64 remainder steps, one wrap and integral step, two passes
// through a shared multiplier for the divisions by 100 and 20, and a final
// state that loads the result once the output is free.
// The next item is taken while a finished result still waits on the output.
// Configuration writes land at once and are scaled to nanoseconds as they land.
module dc_clock_sync_pi_top
    import dcs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  cfg_index_t         cfg_wr_index,
    input  logic [21:0]        cfg_wr_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [62:0]        s_dc_time_ns,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_phase_error_ns,
    output logic signed [27:0] m_compensation
);

    dcs_state_t        state_reg, state_next;
    logic [30:0]       cyc_ns_reg, cyc_ns_next;
    logic [31:0]       off_ns_reg, off_ns_next;
    logic signed [30:0] integ_reg, integ_next;
    logic              m_valid_reg, m_valid_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [63:0]       dvd_reg, dvd_next;
    logic [31:0]       rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic [31:0]       delta_reg, delta_next;
    logic [63:0]       prod_reg, prod_next;
    logic [24:0]       qp_reg, qp_next;
    logic [31:0]       err_out_reg, err_out_next;
    logic [27:0]       comp_out_reg, comp_out_next;

    logic [20:0]       cyc_us;
    logic [64:0]       diff;
    logic [31:0]       trial;
    logic [30:0]       rem_val;
    logic [31:0]       delta_val;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       mul_p;
    logic [30:0]       integ_abs;
    logic [25:0]       qi;
    logic [27:0]       pterm;
    logic [27:0]       iterm;

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_phase_error_ns = err_out_reg;
    assign m_compensation   = comp_out_reg;

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        state_next    = state_reg;
        cyc_ns_next   = cyc_ns_reg;
        off_ns_next   = off_ns_reg;
        integ_next    = integ_reg;
        m_valid_next  = m_valid_reg;
        cnt_next      = cnt_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        delta_next    = delta_reg;
        prod_next     = prod_reg;
        qp_next       = qp_reg;
        err_out_next  = err_out_reg;
        comp_out_next = comp_out_reg;

        cyc_us    = (cfg_wr_data[20:0] == 21'd0) ? 21'd1 : cfg_wr_data[20:0];
        diff      = {2'b00, s_dc_time_ns} - {{33{off_ns_reg[31]}}, off_ns_reg};
        trial     = {rem_reg[30:0], dvd_reg[63]};
        rem_val   = rem_reg[30:0];
        delta_val = 32'd0;
        integ_abs = integ_reg[30] ? 31'(-integ_reg) : 31'(integ_reg);
        qi        = prod_reg[SHIFT_INTEG +: 26];
        pterm     = delta_reg[31] ? 28'(qp_reg) : 28'd0 - 28'(qp_reg);
        iterm     = integ_reg[30] ? 28'(qi) : 28'd0 - 28'(qi);
        mul_a     = 32'd0;
        mul_b     = RECIP_PROP;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_CYCLE_TIME: begin
                    cyc_ns_next = 31'(cyc_us) * 31'(NS_PER_US);
                end
                CFG_MASTER_OFFSET: begin
                    off_ns_next = {{10{cfg_wr_data[21]}}, cfg_wr_data} * 32'(NS_PER_US);
                end
                default: begin
                    cyc_ns_next = cyc_ns_reg;
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next   = diff[64];
                    dvd_next   = diff[64] ? 64'd0 - diff[63:0] : diff[63:0];
                    rem_next   = 32'd0;
                    cnt_next   = 6'd0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = (trial >= {1'b0, cyc_ns_reg}) ? trial - {1'b0, cyc_ns_reg} : trial;
                dvd_next = {dvd_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (neg_reg) begin
                    delta_val = 32'd0 - {1'b0, rem_val};
                end else if (rem_val > (cyc_ns_reg >> 1)) begin
                    delta_val = {1'b0, rem_val} - {1'b0, cyc_ns_reg};
                end else begin
                    delta_val = {1'b0, rem_val};
                end
                delta_next = delta_val;
                if (delta_val != 32'd0 && !delta_val[31] && integ_reg < INTEG_LIMIT) begin
                    integ_next = integ_reg + 31'sd1;
                end
                if (delta_val[31] && integ_reg > -INTEG_LIMIT) begin
                    integ_next = integ_reg - 31'sd1;
                end
                state_next = ST_MULP;
            end
            ST_MULP: begin
                mul_a      = delta_reg[31] ? 32'd0 - delta_reg : delta_reg;
                mul_b      = RECIP_PROP;
                prod_next  = mul_p;
                state_next = ST_MULI;
            end
            ST_MULI: begin
                qp_next    = prod_reg[SHIFT_PROP +: 25];
                mul_a      = 32'(integ_abs);
                mul_b      = RECIP_INTEG;
                prod_next  = mul_p;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    err_out_next  = delta_reg;
                    comp_out_next = pterm + iterm;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cyc_ns_reg  <= CYCLE_NS_RESET;
            off_ns_reg  <= 32'd0;
            integ_reg   <= 31'sd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cyc_ns_reg  <= cyc_ns_next;
            off_ns_reg  <= off_ns_next;
            integ_reg   <= integ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        delta_reg    <= delta_next;
        prod_reg     <= prod_next;
        qp_reg       <= qp_next;
        err_out_reg  <= err_out_next;
        comp_out_reg <= comp_out_next;
    end

endmodule
